// ===== rtl/pfd_pkg.sv =====
// ----------------------------------------------------------------------------
// pfd_pkg
// types and constants shared by the position frame deframer
// ----------------------------------------------------------------------------
package pfd_pkg;

  typedef logic [7:0] byte_t;
  typedef logic signed [15:0] pos_t;
  typedef logic [2:0] idx_t;
  typedef logic [4:0][7:0] frame_t;

  // header restarts a frame, clear byte drops the found flag
  localparam byte_t HDR_BYTE = 8'hFF;
  localparam byte_t CLR_BYTE = 8'hFE;

  // slot of the checksum byte, one past the stored bytes
  localparam idx_t CHK_IDX = 3'd5;
  localparam int STORED_BYTES = 5;

  localparam pos_t POS_LIMIT = 16'sd32700;
  localparam pos_t NEG_LIMIT = -16'sd32700;

  // result of the end-of-frame check
  typedef struct packed {
    logic pass;
    pos_t x;
    pos_t y;
  } pfd_check_t;

endpackage

// ===== rtl/pfd_if.sv =====
// ----------------------------------------------------------------------------
// pfd_byte_if / pfd_pos_if
// valid/ready channels carrying received bytes and position results
// ----------------------------------------------------------------------------
interface pfd_byte_if
  import pfd_pkg::*;
;
  logic  valid;
  logic  ready;
  byte_t rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface pfd_pos_if
  import pfd_pkg::*;
;
  logic valid;
  logic ready;
  pos_t pos_x;
  pos_t pos_y;
  logic target_found;
  logic frame_accepted;

  modport source (output valid, output pos_x, output pos_y, output target_found,
                  output frame_accepted, input ready);
  modport sink (input valid, input pos_x, input pos_y, input target_found,
                input frame_accepted, output ready);
endinterface

// ===== rtl/position_frame_deframer.sv =====
// ----------------------------------------------------------------------------
// position_frame_deframer
// assembles 6-byte position frames from a received byte stream
// ----------------------------------------------------------------------------
// Each received byte on rx gives exactly one result item on pos. A frame is a
// 0xFF header, x and y as big-endian signed 16-bit counts (value = raw/32700)
// and a checksum byte equal to the low 8 bits of the sum of the first five
// bytes. A 0xFF byte restarts the frame wherever it appears; a 0xFE byte
// clears target_found but is still stored as a frame byte. When the sixth
// byte passes the header, checksum and range checks (|x|, |y| <= 32700) the
// position is latched, target_found is set and frame_accepted is high for
// that item. Every result carries the currently held position and flag.
// Throughput is one item per clock while pos is ready. Each item passes the
// input register and then the result register; the frame state is updated in
// the single stage between them. No clearing pass is needed after reset.
// ----------------------------------------------------------------------------
module position_frame_deframer
  import pfd_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  pfd_byte_if.sink          rx,
  pfd_pos_if.source         pos
);

  // input register
  logic  s1_valid;
  byte_t s1_byte;
  logic  s1_advance;

  // frame state
  idx_t   byte_index;
  frame_t frame_bytes;
  pos_t   held_x;
  pos_t   held_y;
  logic   found_flag;

  // next-state values
  idx_t   idx_cur;
  idx_t   byte_index_next;
  frame_t frame_bytes_next;
  pos_t   held_x_next;
  pos_t   held_y_next;
  logic   found_flag_next;
  logic   accepted;

  // result register
  logic res_valid;
  pos_t res_x;
  pos_t res_y;
  logic res_found;
  logic res_accepted;

  pfd_check_t check;

  // the stage moves when the result register is free or being drained
  assign s1_advance = s1_valid && (!res_valid || pos.ready);
  // no item is taken while reset is held
  assign rx.ready   = !rst && (!s1_valid || s1_advance);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (rx.ready) begin
      s1_valid <= rx.valid;
    end
    if (rx.ready && rx.valid) begin
      s1_byte <= rx.rx_byte;
    end
  end

  pfd_frame_check u_check (
    .frame    (frame_bytes),
    .chk_byte (s1_byte),
    .check    (check)
  );

  always_comb begin
    // unreachable index values fall back to the start of a frame
    idx_cur = (byte_index > CHK_IDX) ? '0 : byte_index;
    if (s1_byte == HDR_BYTE) begin
      idx_cur = '0;
    end

    frame_bytes_next = frame_bytes;
    held_x_next      = held_x;
    held_y_next      = held_y;
    found_flag_next  = found_flag;
    accepted         = 1'b0;

    if (s1_byte == CLR_BYTE) begin
      found_flag_next = 1'b0;
    end

    if (idx_cur != CHK_IDX) begin
      // store one of the first five bytes
      for (int i = 0; i < STORED_BYTES; i++) begin
        if (idx_cur == idx_t'(i)) begin
          frame_bytes_next[i] = s1_byte;
        end
      end
      byte_index_next = idx_cur + 3'd1;
    end else begin
      // checksum byte closes the frame whether or not it passes
      if (check.pass) begin
        held_x_next     = check.x;
        held_y_next     = check.y;
        found_flag_next = 1'b1;
        accepted        = 1'b1;
      end
      byte_index_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_index  <= '0;
      frame_bytes <= '0;
      held_x      <= '0;
      held_y      <= '0;
      found_flag  <= 1'b0;
    end else if (s1_advance) begin
      byte_index  <= byte_index_next;
      frame_bytes <= frame_bytes_next;
      held_x      <= held_x_next;
      held_y      <= held_y_next;
      found_flag  <= found_flag_next;
    end
  end

  // result register, holds while the sink stalls
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (s1_advance) begin
      res_valid <= 1'b1;
    end else if (pos.ready) begin
      res_valid <= 1'b0;
    end
    if (s1_advance) begin
      res_x        <= held_x_next;
      res_y        <= held_y_next;
      res_found    <= found_flag_next;
      res_accepted <= accepted;
    end
  end

  assign pos.valid          = res_valid;
  assign pos.pos_x          = res_x;
  assign pos.pos_y          = res_y;
  assign pos.target_found   = res_found;
  assign pos.frame_accepted = res_accepted;

`ifndef SYNTHESIS
  // frame slot never leaves the six reachable values
  a_index_range: assert property (@(posedge clk) disable iff (rst)
    byte_index <= CHK_IDX)
    else $error("byte_index out of range");

  // an accepted frame always leaves the flag set
  a_accept_found: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_accepted |-> res_found)
    else $error("frame accepted without target_found");

  // a header byte always becomes slot zero of a new frame
  a_header_restart: assert property (@(posedge clk) disable iff (rst)
    s1_advance && (s1_byte == HDR_BYTE) |=> (byte_index == 3'd1))
    else $error("header byte did not restart the frame");

  // a clear byte that does not close a good frame leaves the flag low
  a_clear_found: assert property (@(posedge clk) disable iff (rst)
    s1_advance && (s1_byte == CLR_BYTE) && !accepted |=> !found_flag)
    else $error("clear byte did not drop target_found");
`endif

endmodule

// ===== rtl/pfd_frame_check.sv =====
// ----------------------------------------------------------------------------
// pfd_frame_check
// header, additive checksum and range check of a complete frame
// ----------------------------------------------------------------------------
module pfd_frame_check
  import pfd_pkg::*;
(
  input  frame_t     frame,
  input  byte_t      chk_byte,
  output pfd_check_t check
);

  byte_t sum;
  pos_t  x;
  pos_t  y;
  logic  x_ok;
  logic  y_ok;

  // low 8 bits of the sum of header and both coordinates
  assign sum = frame[0] + frame[1] + frame[2] + frame[3] + frame[4];

  // big-endian signed coordinates
  assign x = $signed({frame[1], frame[2]});
  assign y = $signed({frame[3], frame[4]});

  assign x_ok = (x >= NEG_LIMIT) && (x <= POS_LIMIT);
  assign y_ok = (y >= NEG_LIMIT) && (y <= POS_LIMIT);

  assign check.pass = (frame[0] == HDR_BYTE) && (sum == chk_byte) && x_ok && y_ok;
  assign check.x    = x;
  assign check.y    = y;

endmodule

// ===== tb/sv/position_frame_deframer_tb.sv =====
// ----------------------------------------------------------------------------
// position_frame_deframer_tb
// checks the frame deframer against its own bit-accurate software predictor
// ----------------------------------------------------------------------------
// A queue of received bytes is filled by the stimulus process and fed to the
// rx channel by a clocked driver that sends in bursts with random gaps. Every
// accepted byte runs through a local copy of the frame logic, and the result it
// should give is queued. A clocked monitor stalls the pos channel on a shifting
// pattern, once for a long stretch, and compares every result with the oldest
// expectation field by field. Stimulus covers range limits, checksum and header
// errors, restarts by a header byte, clear bytes and cut-short frames.
// ----------------------------------------------------------------------------
module position_frame_deframer_tb;
  import pfd_pkg::*;

  // what one result item should hold
  typedef struct packed {
    pos_t x;
    pos_t y;
    logic found;
    logic accepted;
  } pos_result_t;

  localparam int IDLE_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 8;
  localparam int HOLD_CYCLES = 150;
  localparam int HOLD_AFTER = 200;

  logic clk = 1'b0;
  logic rst = 1'b1;

  pfd_byte_if rx_ch ();
  pfd_pos_if pos_ch ();

  position_frame_deframer dut (
    .clk (clk),
    .rst (rst),
    .rx  (rx_ch),
    .pos (pos_ch)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // bytes still to be sent and results still to come
  byte_t       rx_bytes_pending[$];
  pos_result_t positions_due[$];
  int          stim_count = 0;
  int          mismatches = 0;

  // local copy of the frame state, same reset values as the block
  idx_t  frame_slot = '0;
  byte_t frame_store[STORED_BYTES] = '{default: '0};
  pos_t  latched_x = '0;
  pos_t  latched_y = '0;
  logic  found_now = 1'b0;

  // one received byte through the frame logic, returns the result it gives
  function automatic pos_result_t deframe_byte(byte_t b);
    idx_t        slot;
    byte_t       chk;
    pos_t        fx;
    pos_t        fy;
    pos_result_t r;
    slot = frame_slot;
    r.accepted = 1'b0;
    // indexes past the checksum slot cannot occur, but fold them to zero
    if (slot > CHK_IDX) slot = '0;
    // a header byte restarts the frame wherever it lands
    if (b == HDR_BYTE) slot = '0;
    // clear byte drops the flag before the end-of-frame check
    if (b == CLR_BYTE) found_now = 1'b0;
    if (slot < CHK_IDX) begin
      frame_store[slot] = b;
      frame_slot = slot + 1'b1;
    end else begin
      // 8-bit wrapping sum of header and position bytes
      chk = frame_store[0] + frame_store[1] + frame_store[2] + frame_store[3] +
            frame_store[4];
      fx = {frame_store[1], frame_store[2]};
      fy = {frame_store[3], frame_store[4]};
      if (frame_store[0] == HDR_BYTE && chk == b &&
          fx >= NEG_LIMIT && fx <= POS_LIMIT &&
          fy >= NEG_LIMIT && fy <= POS_LIMIT) begin
        latched_x = fx;
        latched_y = fy;
        found_now = 1'b1;
        r.accepted = 1'b1;
      end
      // the index returns to zero whether the frame passed or not
      frame_slot = '0;
    end
    r.x = latched_x;
    r.y = latched_y;
    r.found = found_now;
    return r;
  endfunction

  task automatic push_byte(input byte_t b);
    rx_bytes_pending.push_back(b);
    stim_count++;
  endtask

  // six-byte frame; chk_xor spoils the checksum when nonzero
  task automatic push_frame(input byte_t hdr, input int x, input int y,
                            input byte_t chk_xor);
    logic [15:0] xv;
    logic [15:0] yv;
    byte_t       chk;
    xv = x[15:0];
    yv = y[15:0];
    chk = hdr + xv[15:8] + xv[7:0] + yv[15:8] + yv[7:0];
    push_byte(hdr);
    push_byte(xv[15:8]);
    push_byte(xv[7:0]);
    push_byte(yv[15:8]);
    push_byte(yv[7:0]);
    push_byte(chk ^ chk_xor);
  endtask

  // coordinate that leans on the range edges and the 16-bit extremes
  function automatic int pick_coord();
    case ($urandom_range(0, 11))
      0: return int'(POS_LIMIT);
      1: return int'(NEG_LIMIT);
      2: return int'(POS_LIMIT) + 1;
      3: return int'(NEG_LIMIT) - 1;
      4: return -32768;
      5: return 32767;
      6: return 0;
      default: return int'($urandom_range(0, 65400)) - 32700;
    endcase
  endfunction

  // mostly whole frames with random content, the rest noise and broken frames
  task automatic random_traffic(input int stop_at);
    int kind;
    while (stim_count < stop_at) begin
      kind = $urandom_range(0, 19);
      if (kind < 12) begin
        push_frame(HDR_BYTE, pick_coord(), pick_coord(), 8'h00);
      end else if (kind == 12) begin
        // checksum off by a random pattern
        push_frame(HDR_BYTE, pick_coord(), pick_coord(), byte_t'($urandom_range(1, 255)));
      end else if (kind == 13) begin
        // anything but a header in the first slot
        push_frame(byte_t'($urandom_range(0, 254)), pick_coord(), pick_coord(), 8'h00);
      end else if (kind == 14) begin
        // frame cut short, the next header restarts it
        push_byte(HDR_BYTE);
        repeat ($urandom_range(1, 4)) push_byte(byte_t'($urandom_range(0, 255)));
      end else if (kind == 15) begin
        repeat ($urandom_range(1, 3)) push_byte(byte_t'($urandom_range(0, 255)));
      end else if (kind == 16) begin
        push_byte(CLR_BYTE);
      end else if (kind == 17) begin
        // header byte in the checksum slot opens a new frame instead
        push_byte(HDR_BYTE);
        repeat (4) push_byte(byte_t'($urandom_range(0, 255)));
        push_byte(HDR_BYTE);
      end else if (kind == 18) begin
        // clear byte as the high byte of x
        push_frame(HDR_BYTE, int'(pos_t'({CLR_BYTE, byte_t'($urandom_range(0, 255))})),
                   pick_coord(), 8'h00);
      end else begin
        push_frame(HDR_BYTE, pick_coord(),
                   int'(pos_t'({CLR_BYTE, byte_t'($urandom_range(0, 255))})), 8'h00);
      end
    end
  endtask

  // sampled away from the rising edge so the driver and monitor have settled
  task automatic wait_drained();
    while (rx_bytes_pending.size() != 0 || rx_ch.valid || positions_due.size() != 0)
      @(negedge clk);
  endtask

  // stimulus: directed frames, then two random phases with a full drain between
  initial begin
    int phase_base;
    rx_ch.valid = 1'b0;
    rx_ch.rx_byte = '0;
    pos_ch.ready = 1'b0;

    // both range limits, and the checksum comes out as the clear byte
    push_frame(HDR_BYTE, int'(POS_LIMIT), int'(NEG_LIMIT), 8'h00);
    // lone clear byte, then a frame with no header
    push_byte(CLR_BYTE);
    push_byte(8'h12);
    // header mid-frame restarts; both coordinates one past the limit
    push_frame(HDR_BYTE, int'(POS_LIMIT) + 1, int'(NEG_LIMIT) - 1, 8'h00);
    // bad checksum
    push_frame(HDR_BYTE, int'(NEG_LIMIT), int'(POS_LIMIT), 8'h80);
    // bad header with a valid checksum
    push_frame(8'h00, 1, 2, 8'h00);

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    wait_drained();
    phase_base = stim_count;
    random_traffic(phase_base + 450);
    // sender holds back until every result is in
    wait_drained();
    random_traffic(phase_base + 900);
    wait_drained();

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("position_frame_deframer_tb OK");
    end else begin
      $display("position_frame_deframer_tb NOT OK");
    end
    $finish;
  end

  // driver: bursts of items with random gaps, valid held until accepted
  int burst_left = 1;
  int gap_left = 0;

  always @(posedge clk) begin
    if (rst) begin
      rx_ch.valid <= 1'b0;
      rx_ch.rx_byte <= '0;
      gap_left = 0;
    end else begin
      if (rx_ch.valid && rx_ch.ready) begin
        positions_due.push_back(deframe_byte(rx_ch.rx_byte));
      end
      if (!rx_ch.valid || rx_ch.ready) begin
        if (gap_left > 0) begin
          gap_left--;
          rx_ch.valid <= 1'b0;
        end else if (rx_bytes_pending.size() > 0) begin
          rx_ch.valid <= 1'b1;
          rx_ch.rx_byte <= rx_bytes_pending.pop_front();
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 24);
            // a zero gap joins two bursts into one long stretch
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
          end else begin
            burst_left--;
          end
        end else begin
          rx_ch.valid <= 1'b0;
        end
      end
    end
  end

  // monitor: checks results and drives ready on a pattern that shifts over time
  int unsigned rcv_cycle = 0;
  int          results_seen = 0;
  int          hold_left = 0;
  bit          hold_done = 1'b0;

  always @(posedge clk) begin
    pos_result_t want;
    if (rst) begin
      pos_ch.ready <= 1'b0;
    end else begin
      rcv_cycle++;
      if (pos_ch.valid && pos_ch.ready) begin
        results_seen++;
        if (positions_due.size() == 0) begin
          $error("result item with no expectation waiting");
          mismatches++;
        end else begin
          want = positions_due.pop_front();
          if (pos_ch.pos_x !== want.x) begin
            $error("pos_x: expected %0d, got %0d", want.x, pos_ch.pos_x);
            mismatches++;
          end
          if (pos_ch.pos_y !== want.y) begin
            $error("pos_y: expected %0d, got %0d", want.y, pos_ch.pos_y);
            mismatches++;
          end
          if (pos_ch.target_found !== want.found) begin
            $error("target_found: expected %0b, got %0b", want.found,
                   pos_ch.target_found);
            mismatches++;
          end
          if (pos_ch.frame_accepted !== want.accepted) begin
            $error("frame_accepted: expected %0b, got %0b", want.accepted,
                   pos_ch.frame_accepted);
            mismatches++;
          end
        end
      end
      // one long hold-off mid-run so the block backs up into its input
      if (hold_left > 0) begin
        hold_left--;
        pos_ch.ready <= 1'b0;
      end else if (!hold_done && results_seen >= HOLD_AFTER) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
        pos_ch.ready <= 1'b0;
      end else begin
        case (rcv_cycle[8:7])
          2'd0: pos_ch.ready <= 1'b1;
          2'd1: pos_ch.ready <= 1'($urandom_range(0, 1));
          2'd2: pos_ch.ready <= (rcv_cycle[1:0] == 2'd0);
          default: pos_ch.ready <= ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  // watchdog: too long with no item moving on either side ends the run
  int idle_cycles = 0;

  always @(posedge clk) begin
    if (rst || (rx_ch.valid && rx_ch.ready) || (pos_ch.valid && pos_ch.ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("position_frame_deframer_tb NOT OK");
        $finish;
      end
    end
  end

endmodule

// ===== sim.f =====
rtl/pfd_pkg.sv
rtl/pfd_if.sv
rtl/pfd_frame_check.sv
rtl/position_frame_deframer.sv
tb/sv/position_frame_deframer_tb.sv
